FILE: src/vpc_pkg.sv
`default_nettype none
package vpc_pkg;

  // Screen size in pixels.
  localparam int SCREEN_WIDTH  = 800;
  localparam int SCREEN_HEIGHT = 800;

  localparam int SCR_MAX  = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
  localparam int SCR_BITS = $clog2(SCR_MAX + 1);
  // Quotient bits: every in-range pixel magnitude fits, larger ones are culled.
  localparam int QB       = $clog2(2 * SCR_MAX + 1);

  localparam int CW    = 32;              // Q16.16 word
  localparam int PW    = 2 * CW;          // full product
  localparam int AW    = 50;              // transformed coordinate
  localparam int NW    = AW + 2 + SCR_BITS; // scaled numerator, signed
  localparam int MW    = NW + 1;          // divider magnitudes
  localparam int PIXW  = 12;
  localparam int SQW   = (QB + 1 > PIXW) ? QB + 1 : PIXW;

  localparam int NUM_REGS = 8;
  localparam int REG_W    = 64;
  localparam int IDX_W    = 4;

  localparam logic [CW-1:0] ONE_Q16 = 32'h0001_0000;

  // Matrix entries, [row][column].
  typedef logic [3:0][3:0][CW-1:0] matrix_t;

  typedef struct packed {
    logic signed [AW-1:0] xn;
    logic signed [AW-1:0] yn;
    logic signed [AW-1:0] zn;
    logic signed [AW-1:0] w;
  } vec4_t;

  typedef struct packed {
    logic          vis;
    logic          neg_x;
    logic          neg_y;
    logic [MW-1:0] rx;
    logic [MW-1:0] ry;
    logic [MW-1:0] d;
    logic [QB-1:0] qx;
    logic [QB-1:0] qy;
  } div_t;

endpackage
`default_nettype wire

FILE: src/vpc_transform.sv
`default_nettype none
module vpc_transform (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     en,
  input  wire logic                     in_valid,
  input  wire logic [vpc_pkg::CW-1:0]   pos_x,
  input  wire logic [vpc_pkg::CW-1:0]   pos_y,
  input  wire logic [vpc_pkg::CW-1:0]   pos_z,
  input  wire vpc_pkg::matrix_t         mat,
  output logic                          out_valid,
  output vpc_pkg::vec4_t                out_vec
);
  import vpc_pkg::*;

  logic signed [PW-1:0] prod [4][3];
  logic signed [CW-1:0] c3 [4];
  logic                 v1;
  logic signed [AW-1:0] sum [4];

  // Stage 1: twelve products of the point and the matrix.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        prod[r][0] <= $signed(pos_x) * $signed(mat[r][0]);
        prod[r][1] <= $signed(pos_y) * $signed(mat[r][1]);
        prod[r][2] <= $signed(pos_z) * $signed(mat[r][2]);
        c3[r]      <= $signed(mat[r][3]);
      end
    end
  end

  // Stage 2: floor each product to Q16.16 and add the translation.
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      sum[r] = {{(AW-PW+16){prod[r][0][PW-1]}}, prod[r][0][PW-1:16]}
             + {{(AW-PW+16){prod[r][1][PW-1]}}, prod[r][1][PW-1:16]}
             + {{(AW-PW+16){prod[r][2][PW-1]}}, prod[r][2][PW-1:16]}
             + {{(AW-CW){c3[r][CW-1]}}, c3[r]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v1;
    end
    if (en) begin
      out_vec.xn <= sum[0];
      out_vec.yn <= sum[1];
      out_vec.zn <= sum[2];
      out_vec.w  <= sum[3];
    end
  end

endmodule
`default_nettype wire

FILE: src/vpc_setup.sv
`default_nettype none
module vpc_setup (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  wire vpc_pkg::vec4_t  in_vec,
  output logic                 out_valid,
  output vpc_pkg::div_t        out_div
);
  import vpc_pkg::*;

  localparam logic signed [NW-1:0] SW = NW'(SCREEN_WIDTH);
  localparam logic signed [NW-1:0] SH = NW'(SCREEN_HEIGHT);

  logic signed [AW-1:0] wf;
  logic                 depth_ok;

  // Stage 3 registers.
  logic                 v3, vis3, wneg3;
  logic signed [AW:0]   ax3, ay3;
  logic [AW-1:0]        aw3;

  // Stage 4 registers.
  logic                 v4, vis4, wneg4;
  logic signed [NW-1:0] nx4, ny4;
  logic [MW-1:0]        d4;

  logic                 neg_x, neg_y, ovx, ovy;
  logic [MW-1:0]        magx, magy, dlim;

  always_comb begin
    wf = (in_vec.w == '0) ? AW'($signed(ONE_Q16)) : in_vec.w;
    if (!wf[AW-1]) begin
      depth_ok = !in_vec.zn[AW-1] && (in_vec.zn <= wf);
    end else begin
      depth_ok = (in_vec.zn[AW-1] || (in_vec.zn == '0)) && (in_vec.zn >= wf);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v3 <= in_valid;
      v4 <= v3;
      out_valid <= v4;
    end
    if (en) begin
      // Stage 3: divisor fix, depth test, numerator sums.
      vis3  <= depth_ok;
      wneg3 <= wf[AW-1];
      ax3   <= {in_vec.xn[AW-1], in_vec.xn} + {wf[AW-1], wf};
      ay3   <= {wf[AW-1], wf} - {in_vec.yn[AW-1], in_vec.yn};
      aw3   <= wf[AW-1] ? AW'(-wf) : AW'(wf);
      // Stage 4: scale by the screen size, form the divisor 2|w|.
      vis4  <= vis3;
      wneg4 <= wneg3;
      nx4   <= SW * {{(NW-AW-1){ax3[AW]}}, ax3};
      ny4   <= SH * {{(NW-AW-1){ay3[AW]}}, ay3};
      d4    <= {{(MW-AW-1){1'b0}}, aw3, 1'b0};
    end
  end

  // Stage 5: magnitudes and the early cull of quotients too wide to be on screen.
  always_comb begin
    neg_x = nx4[NW-1] ^ wneg4;
    neg_y = ny4[NW-1] ^ wneg4;
    magx  = nx4[NW-1] ? MW'(-{nx4[NW-1], nx4}) : {1'b0, nx4};
    magy  = ny4[NW-1] ? MW'(-{ny4[NW-1], ny4}) : {1'b0, ny4};
    dlim  = d4 << QB;
    ovx   = magx >= dlim;
    ovy   = magy >= dlim;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_div.vis   <= vis4 && !ovx && !ovy;
      out_div.neg_x <= neg_x;
      out_div.neg_y <= neg_y;
      out_div.rx    <= magx;
      out_div.ry    <= magy;
      out_div.d     <= d4;
      out_div.qx    <= '0;
      out_div.qy    <= '0;
    end
  end

endmodule
`default_nettype wire

FILE: src/vpc_divider.sv
`default_nettype none
module vpc_divider (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  wire vpc_pkg::div_t   in_div,
  output logic                 out_valid,
  output vpc_pkg::div_t        out_div
);
  import vpc_pkg::*;

  // Restoring division, one quotient bit per stage, most significant first.
  div_t stg [QB+1];
  logic vld [QB+1];

  assign stg[0] = in_div;
  assign vld[0] = in_valid;

  for (genvar i = 0; i < QB; i++) begin : g_step
    localparam int B = QB - 1 - i;
    div_t          nxt;
    logic [MW-1:0] sub;

    always_comb begin
      nxt = stg[i];
      sub = stg[i].d << B;
      if (stg[i].rx >= sub) begin
        nxt.rx    = stg[i].rx - sub;
        nxt.qx[B] = 1'b1;
      end
      if (stg[i].ry >= sub) begin
        nxt.ry    = stg[i].ry - sub;
        nxt.qy[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
      if (en) begin
        stg[i+1] <= nxt;
      end
    end
  end

  assign out_div   = stg[QB];
  assign out_valid = vld[QB];

endmodule
`default_nettype wire

FILE: src/vertex_project_cull_unit.sv
`default_nettype none
// Perspective transform, depth cull and viewport mapping of one point per transaction.
//
// Input stream (s_*): one transaction carries a point as three signed Q16.16 words.
// Output stream (m_*): one transaction per input carries the visible flag and the
// pixel column and row (row flipped), both zero when the point is culled.
// Configuration: a write with cfg_we high loads the 64-bit matrix register named by
// cfg_index; indexes above 7 are ignored. Writes belong to idle periods.
//
// The pipeline takes one transaction every cycle while the receiver does not stall it.
// From input to output register a point passes the matrix multiply and sum, the
// divisor setup, the divider over QB quotient bits (QB = 11 for an 800 pixel
// screen) and the output register, with the sign and range checks in front
// of it. The divider length follows from the screen size.
//
// Reset loads the identity matrix and empties every stage. When the receiver holds
// m_tready low with a result waiting, the whole pipeline freezes and s_tready drops;
// no transaction is lost or repeated.
module vertex_project_cull_unit (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // Input stream; s_tdata fields from bit 0: pos_x, pos_y, pos_z.
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  input  wire logic [95:0]                s_tdata,
  // Output stream; m_tdata fields from bit 0: visible, pixel column, pixel row.
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  output logic [31:0]                     m_tdata,
  // Configuration write port.
  input  wire logic                       cfg_we,
  input  wire logic [vpc_pkg::IDX_W-1:0]  cfg_index,
  input  wire logic [vpc_pkg::REG_W-1:0]  cfg_data
);
  import vpc_pkg::*;

  logic [REG_W-1:0] mreg [NUM_REGS];
  matrix_t          mat;
  logic             en;

  logic  tv_valid, su_valid, dv_valid;
  vec4_t tv_vec;
  div_t  su_div, dv_div;

  logic                 okx, oky, vis;
  logic signed [SQW-1:0] sqx, sqy;

  // Matrix registers; each holds two columns of one row.
  always_ff @(posedge clk) begin
    if (rst) begin
      mreg[0] <= REG_W'(ONE_Q16);
      mreg[1] <= '0;
      mreg[2] <= {ONE_Q16, {CW{1'b0}}};
      mreg[3] <= '0;
      mreg[4] <= '0;
      mreg[5] <= REG_W'(ONE_Q16);
      mreg[6] <= '0;
      mreg[7] <= {ONE_Q16, {CW{1'b0}}};
    end else if (cfg_we && (cfg_index < IDX_W'(NUM_REGS))) begin
      mreg[cfg_index[$clog2(NUM_REGS)-1:0]] <= cfg_data;
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      mat[r][0] = mreg[2*r][CW-1:0];
      mat[r][1] = mreg[2*r][REG_W-1:CW];
      mat[r][2] = mreg[2*r+1][CW-1:0];
      mat[r][3] = mreg[2*r+1][REG_W-1:CW];
    end
  end

  // Every stage advances together unless a result is waiting on a stalled receiver.
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  vpc_transform u_transform (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .pos_x     (s_tdata[31:0]),
    .pos_y     (s_tdata[63:32]),
    .pos_z     (s_tdata[95:64]),
    .mat       (mat),
    .out_valid (tv_valid),
    .out_vec   (tv_vec)
  );

  vpc_setup u_setup (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (tv_valid),
    .in_vec    (tv_vec),
    .out_valid (su_valid),
    .out_div   (su_div)
  );

  vpc_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (su_valid),
    .in_div    (su_div),
    .out_valid (dv_valid),
    .out_div   (dv_div)
  );

  // Quotients truncate toward zero, so the sign is applied to the magnitude.
  // A negative pixel may reach minus one screen, a positive one two screens.
  always_comb begin
    sqx = dv_div.neg_x ? -SQW'(dv_div.qx) : SQW'(dv_div.qx);
    sqy = dv_div.neg_y ? -SQW'(dv_div.qy) : SQW'(dv_div.qy);
    okx = dv_div.neg_x ? (dv_div.qx <= QB'(SCREEN_WIDTH))
                       : (dv_div.qx <= QB'(2 * SCREEN_WIDTH));
    oky = dv_div.neg_y ? (dv_div.qy <= QB'(SCREEN_HEIGHT))
                       : (dv_div.qy <= QB'(2 * SCREEN_HEIGHT));
    vis = dv_div.vis && okx && oky;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= dv_valid;
    end
    if (en) begin
      m_tdata <= {7'd0,
                  vis ? sqy[PIXW-1:0] : {PIXW{1'b0}},
                  vis ? sqx[PIXW-1:0] : {PIXW{1'b0}},
                  vis};
    end
  end

endmodule
`default_nettype wire
